### hdl/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types and constants of the JSON string unescaper: the input item,
// the result item, error codes and the job record passed from decoder to
// serializer.
// ============================================================================
package jsu_pkg;

    // Most results one input byte can cause.
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // Default depth of the job queue between decoder and serializer.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_ESCAPE = 3'd1,
        ERR_HEX    = 3'd2,
        ERR_CTRL   = 3'd3,
        ERR_LEAD   = 3'd4,
        ERR_TRUNC  = 3'd5
    } err_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       single_quoted;
        logic       string_end;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        err_t       error_code;
        logic       run_last;
        logic       string_done;
    } result_t;

    // One decoded result before the end-of-run flags are attached.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        err_t       err;
    } piece_t;

    // All results of one input byte.
    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        piece_t [MAX_RESULTS-1:0]        piece;
        logic                            done;
    } job_t;

endpackage

### hdl/jsu_front.sv
// ============================================================================
// jsu_front
// Decoder: takes one raw string byte per cycle while take is high, tracks the
// escape and UTF-8 state and makes the byte a job of zero to four result pieces.
// ============================================================================
module jsu_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  jsu_pkg::item_t   item,
    output logic             job_push,
    output jsu_pkg::job_t    job
);

    typedef enum logic [2:0] {
        M_TEXT,
        M_ESC,
        M_HEX1,
        M_SBS,
        M_SU,
        M_HEX2,
        M_CONT,
        M_ERR
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CTRL_MAX  = 8'h1F;
    localparam logic [7:0] LEAD2     = 8'hC0;
    localparam logic [7:0] LEAD3     = 8'hE0;
    localparam logic [7:0] LEAD4     = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [15:0] HIGH_LO  = 16'hD800;
    localparam logic [15:0] HIGH_HI  = 16'hDBFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    mode_t       mode_reg, mode_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [11:0] acc_reg,  acc_next;
    logic [9:0]  high_reg, high_next;
    logic [1:0]  cont_reg, cont_next;

    function automatic jsu_pkg::job_t add_piece(jsu_pkg::job_t j, logic [7:0] b, logic v,
                                                 jsu_pkg::err_t e);
        jsu_pkg::job_t r;
        r = j;
        if (j.cnt < jsu_pkg::CNT_W'(jsu_pkg::MAX_RESULTS))
        begin
            r.piece[j.cnt[jsu_pkg::IDX_W-1:0]] = '{data: b, valid: v, err: e};
            r.cnt = j.cnt + 1'b1;
        end
        return r;
    endfunction

    // Encode one code point as UTF-8 and append its bytes.
    function automatic jsu_pkg::job_t add_cp(jsu_pkg::job_t j, logic [20:0] cp);
        jsu_pkg::job_t   r;
        logic [2:0]      len;
        logic [3:0][7:0] bytes;
        r     = j;
        bytes = '0;
        if (cp[20:7] == '0)
        begin
            len      = 3'd1;
            bytes[0] = cp[7:0];
        end
        else if (cp[20:11] == '0)
        begin
            len      = 3'd2;
            bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
        end
        else if (cp[20:16] == '0)
        begin
            len      = 3'd3;
            bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
        end
        else
        begin
            len      = 3'd4;
            bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
        end
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < len)
            begin
                r = add_piece(r, bytes[i], 1'b1, jsu_pkg::ERR_NONE);
            end
        end
        return r;
    endfunction

    function automatic logic [20:0] lone_cp(logic [9:0] h);
        return {5'b00000, 6'b110110, h};
    endfunction

    logic [7:0]  b;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] code16;
    logic        do_text;
    logic        do_esc;

    assign b      = item.in_byte;
    assign code16 = {acc_reg, hex_val};

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            hex_val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            hex_val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            hex_val = 4'(b - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    always_comb
    begin
        job       = '0;
        mode_next = mode_reg;
        hcnt_next = hcnt_reg;
        acc_next  = acc_reg;
        high_next = high_reg;
        cont_next = cont_reg;
        do_text   = 1'b0;
        do_esc    = 1'b0;

        unique case (mode_reg)
            M_TEXT:
            begin
                do_text = 1'b1;
            end
            M_ESC:
            begin
                do_esc = 1'b1;
            end
            M_HEX1, M_HEX2:
            begin
                if (!hex_ok)
                begin
                    job       = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_HEX);
                    mode_next = M_ERR;
                    hcnt_next = '0;
                    acc_next  = '0;
                    cont_next = '0;
                end
                else if (hcnt_reg != 2'd3)
                begin
                    acc_next  = {acc_reg[7:0], hex_val};
                    hcnt_next = hcnt_reg + 2'd1;
                end
                else
                begin
                    hcnt_next = '0;
                    acc_next  = '0;
                    if (mode_reg == M_HEX2)
                    begin
                        job = add_cp(job, SUPP_BASE + {1'b0, high_reg, code16[9:0]});
                        mode_next = M_TEXT;
                    end
                    else if (code16 >= HIGH_LO && code16 <= HIGH_HI)
                    begin
                        high_next = code16[9:0];
                        mode_next = M_SBS;
                    end
                    else
                    begin
                        job       = add_cp(job, {5'b00000, code16});
                        mode_next = M_TEXT;
                    end
                end
            end
            M_SBS:
            begin
                if (b == CH_BSLASH)
                begin
                    mode_next = M_SU;
                end
                else
                begin
                    job       = add_cp(job, lone_cp(high_reg));
                    mode_next = M_TEXT;
                    do_text   = 1'b1;
                end
            end
            M_SU:
            begin
                if (b == CH_LOW_U)
                begin
                    mode_next = M_HEX2;
                    hcnt_next = '0;
                    acc_next  = '0;
                end
                else
                begin
                    job    = add_cp(job, lone_cp(high_reg));
                    do_esc = 1'b1;
                end
            end
            M_CONT:
            begin
                job       = add_piece(job, b, 1'b1, jsu_pkg::ERR_NONE);
                cont_next = cont_reg - 2'd1;
                if (cont_reg == 2'd1)
                begin
                    mode_next = M_TEXT;
                end
            end
            M_ERR:
            begin
                // drop bytes until the string closes
            end
            default:
            begin
            end
        endcase

        if (do_text)
        begin
            if (b == CH_BSLASH)
            begin
                mode_next = M_ESC;
            end
            else if (!b[7])
            begin
                if (b <= CTRL_MAX)
                begin
                    job       = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_CTRL);
                    mode_next = M_ERR;
                    hcnt_next = '0;
                    acc_next  = '0;
                    cont_next = '0;
                end
                else
                begin
                    job = add_piece(job, b, 1'b1, jsu_pkg::ERR_NONE);
                end
            end
            else if (b[7:5] != 3'b110 && b[7:4] != 4'b1110 && b[7:3] != 5'b11110)
            begin
                job       = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_LEAD);
                mode_next = M_ERR;
                hcnt_next = '0;
                acc_next  = '0;
                cont_next = '0;
            end
            else if (item.string_end)
            begin
                job       = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_TRUNC);
                mode_next = M_ERR;
                hcnt_next = '0;
                acc_next  = '0;
                cont_next = '0;
            end
            else
            begin
                job       = add_piece(job, b, 1'b1, jsu_pkg::ERR_NONE);
                mode_next = M_CONT;
                if (b[7:5] == 3'b110)
                begin
                    cont_next = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    cont_next = 2'd2;
                end
                else
                begin
                    cont_next = 2'd3;
                end
            end
        end

        if (do_esc)
        begin
            mode_next = M_TEXT;
            unique case (b)
                CH_DQUOTE: job = add_piece(job, CH_DQUOTE, 1'b1, jsu_pkg::ERR_NONE);
                CH_BSLASH: job = add_piece(job, CH_BSLASH, 1'b1, jsu_pkg::ERR_NONE);
                CH_SLASH:  job = add_piece(job, CH_SLASH, 1'b1, jsu_pkg::ERR_NONE);
                CH_LOW_B:  job = add_piece(job, 8'h08, 1'b1, jsu_pkg::ERR_NONE);
                CH_LOW_F:  job = add_piece(job, 8'h0C, 1'b1, jsu_pkg::ERR_NONE);
                CH_LOW_N:  job = add_piece(job, 8'h0A, 1'b1, jsu_pkg::ERR_NONE);
                CH_LOW_R:  job = add_piece(job, 8'h0D, 1'b1, jsu_pkg::ERR_NONE);
                CH_LOW_T:  job = add_piece(job, 8'h09, 1'b1, jsu_pkg::ERR_NONE);
                CH_APOS:
                begin
                    if (item.single_quoted)
                    begin
                        job = add_piece(job, CH_APOS, 1'b1, jsu_pkg::ERR_NONE);
                    end
                    else
                    begin
                        job       = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_ESCAPE);
                        mode_next = M_ERR;
                        hcnt_next = '0;
                        acc_next  = '0;
                        cont_next = '0;
                    end
                end
                CH_LOW_U:
                begin
                    mode_next = M_HEX1;
                    hcnt_next = '0;
                    acc_next  = '0;
                end
                default:
                begin
                    job       = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_ESCAPE);
                    mode_next = M_ERR;
                    hcnt_next = '0;
                    acc_next  = '0;
                    cont_next = '0;
                end
            endcase
        end

        // Close the string: flush what is pending, then return to reset state.
        if (item.string_end)
        begin
            unique case (mode_next)
                M_ESC, M_SU: job = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_ESCAPE);
                M_HEX1, M_HEX2: job = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_HEX);
                M_SBS: job = add_cp(job, lone_cp(high_next));
                M_CONT: job = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_TRUNC);
                default:
                begin
                end
            endcase
            mode_next = M_TEXT;
            hcnt_next = '0;
            acc_next  = '0;
            high_next = '0;
            cont_next = '0;
            if (job.cnt == '0)
            begin
                job = add_piece(job, 8'h00, 1'b0, jsu_pkg::ERR_NONE);
            end
        end
        job.done = item.string_end;
    end

    assign job_push = take && (job.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_TEXT;
            hcnt_reg <= '0;
            acc_reg  <= '0;
            high_reg <= '0;
            cont_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            hcnt_reg <= hcnt_next;
            acc_reg  <= acc_next;
            high_reg <= high_next;
            cont_reg <= cont_next;
        end
    end

endmodule

### hdl/jsu_queue.sv
// ============================================================================
// jsu_queue
// Short job queue that decouples the decoder from the serializer.
// ============================================================================
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  jsu_pkg::job_t  wr_data,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output jsu_pkg::job_t  rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/jsu_back.sv
// ============================================================================
// jsu_back
// Serializer: walks the pieces of the head job one per cycle into the result
// register while it is empty or popped, and marks the last result of each job.
// ============================================================================
module jsu_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  jsu_pkg::job_t     job,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output jsu_pkg::result_t  result
);

    logic [jsu_pkg::IDX_W-1:0] idx_reg,  idx_next;
    logic                      full_reg, full_next;
    jsu_pkg::result_t          out_reg,  out_next;
    logic                      advance;
    logic                      last;
    jsu_pkg::piece_t           cur;

    assign empty   = !full_reg;
    assign result  = out_reg;
    assign advance = !full_reg || pop;
    assign cur     = job.piece[idx_reg];
    assign last    = (jsu_pkg::CNT_W'(idx_reg) == job.cnt - 1'b1);
    assign job_pop = job_valid && advance && last;

    always_comb
    begin
        idx_next  = idx_reg;
        full_next = full_reg;
        out_next  = out_reg;
        if (job_valid && advance)
        begin
            out_next.out_byte    = cur.data;
            out_next.out_valid   = cur.valid;
            out_next.error_code  = cur.err;
            out_next.run_last    = last;
            out_next.string_done = last && job.done;
            full_next            = 1'b1;
            idx_next             = last ? '0 : idx_reg + 1'b1;
        end
        else if (pop)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            full_reg <= full_next;
        end
    end

endmodule

### hdl/json_string_unescape_utf8_top.sv
// ============================================================================
// json_string_unescape_utf8_top
// Streaming JSON string unescaper: raw string-body bytes in, UTF-8 out.
// ============================================================================
// Feed the bytes of one quoted string body through push/full, one transfer
// per byte, with string_end set on the last byte. Each byte yields zero to
// four results on the empty/pop side; run_last marks the last result of a
// byte and string_done the last result of a string. Simple escapes, \uXXXX
// (with surrogate pairing) and the single-quote escape are decoded; an error
// gives one result with out_valid low and the error code, after which bytes
// are dropped until the string ends. A byte is taken every cycle while the
// job queue has room; the serializer drains one result per cycle while its
// result register is empty or popped, and the decoder keeps filling the
// QUEUE_DEPTH-entry job queue while a byte's results drain. The first result
// of a byte passes through the job queue and the result register to the ports.
// ============================================================================
module json_string_unescape_utf8_top #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  jsu_pkg::item_t    item,
    output logic              empty,
    input  logic              pop,
    output jsu_pkg::result_t  result
);

    logic           take;
    logic           front_push;
    jsu_pkg::job_t  front_job;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    jsu_pkg::job_t  q_job;

    // Accept a byte whenever the job queue can hold its results.
    assign full = q_full;
    assign take = push && !q_full;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .job_push (front_push),
        .job      (front_job)
    );

    // Hold decoded jobs while the serializer works through multibyte output.
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_push),
        .wr_data  (front_job),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_job)
    );

    // Advance one result per cycle into the output register if free or popped.
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job),
        .job_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

### hdl/jsu_checker.sv
// ============================================================================
// jsu_checker
// Port-level checks on the result side of the unescaper.
// ============================================================================
module jsu_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  logic              pop,
    input  jsu_pkg::result_t  result
);

    // Hold a waiting result until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("result changed while waiting");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !result.out_valid |-> result.out_byte == 8'h00)
        else $error("non-data result carries a byte");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.string_done |-> result.run_last)
        else $error("string closed on a result that is not last of its byte");

    a_err_nodata: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.error_code != jsu_pkg::ERR_NONE |-> !result.out_valid)
        else $error("error result marked as data");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

### bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the streaming JSON string unescaper. Raw string
// bytes go in through push/full, a bit-accurate predictor in the bench
// expands each accepted byte into its UTF-8 results, and every result popped
// from the block is compared field by field with the oldest expected one.
// ============================================================================
module tb;

    // Decoder modes of the predictor.
    typedef enum logic [2:0] {
        MD_TEXT,
        MD_ESC,
        MD_HEX1,
        MD_SBS,
        MD_SU,
        MD_HEX2,
        MD_CONT,
        MD_ERR
    } dec_mode_t;

    // One raw byte waiting to be sent; hold_for_drain makes the sender wait
    // until every expected result has been popped before this byte goes out.
    typedef struct {
        jsu_pkg::item_t it;
        bit             hold_for_drain;
    } raw_byte_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam int TARGET_BYTES   = 360;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int TAIL_CYCLES    = 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             push;
    logic             full;
    jsu_pkg::item_t   item;
    logic             empty;
    logic             pop;
    jsu_pkg::result_t result;

    json_string_unescape_utf8_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Stores shared by stimulus, driver and monitor
    // ------------------------------------------------------------------
    raw_byte_t        raw_q[$];        // bytes still to be sent
    jsu_pkg::result_t decoded_q[$];    // expected results, oldest first
    logic [7:0]       str_bytes[$];    // string under construction
    int               mismatches = 0;
    int               popped     = 0;
    int               cycles     = 0;
    bit               took_byte  = 1'b0;

    // ------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------
    dec_mode_t        mode      = MD_TEXT;
    logic [2:0]       hex_n     = '0;
    logic [15:0]      accum     = '0;
    logic [9:0]       hi_bits   = '0;
    logic [1:0]       cont_left = '0;
    jsu_pkg::result_t step_res [jsu_pkg::MAX_RESULTS];
    int               step_n;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Append one result; anything past the fourth is dropped.
    task automatic put_res(input logic [7:0] b, input logic v, input jsu_pkg::err_t e);
        if (step_n < jsu_pkg::MAX_RESULTS)
        begin
            step_res[step_n].out_byte    = b;
            step_res[step_n].out_valid   = v;
            step_res[step_n].error_code  = e;
            step_res[step_n].run_last    = 1'b0;
            step_res[step_n].string_done = 1'b0;
            step_n++;
        end
    endtask

    // Report the error and drop bytes until the string ends.
    task automatic fail_with(input jsu_pkg::err_t e);
        put_res(8'h00, 1'b0, e);
        mode      = MD_ERR;
        hex_n     = '0;
        accum     = '0;
        cont_left = '0;
    endtask

    task automatic emit_code(input logic [20:0] cp);
        if (cp <= 21'h7F)
            put_res(cp[7:0], 1'b1, jsu_pkg::ERR_NONE);
        else if (cp <= 21'h7FF)
        begin
            put_res({3'b110, cp[10:6]}, 1'b1, jsu_pkg::ERR_NONE);
            put_res({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ERR_NONE);
        end
        else if (cp <= 21'hFFFF)
        begin
            put_res({4'b1110, cp[15:12]}, 1'b1, jsu_pkg::ERR_NONE);
            put_res({2'b10, cp[11:6]}, 1'b1, jsu_pkg::ERR_NONE);
            put_res({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ERR_NONE);
        end
        else
        begin
            put_res({5'b11110, cp[20:18]}, 1'b1, jsu_pkg::ERR_NONE);
            put_res({2'b10, cp[17:12]}, 1'b1, jsu_pkg::ERR_NONE);
            put_res({2'b10, cp[11:6]}, 1'b1, jsu_pkg::ERR_NONE);
            put_res({2'b10, cp[5:0]}, 1'b1, jsu_pkg::ERR_NONE);
        end
    endtask

    // A pending high surrogate that found no partner is encoded on its own.
    task automatic emit_lone();
        emit_code({5'b0, 6'b110110, hi_bits});
    endtask

    function automatic int hex_nibble_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c - 8'h61) + 10;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    task automatic text_in(input logic [7:0] b, input logic fin);
        logic [1:0] more;
        if (b == CH_BSLASH)
        begin
            mode = MD_ESC;
            return;
        end
        if (!b[7])
        begin
            if (b <= 8'h1F)
                fail_with(jsu_pkg::ERR_CTRL);
            else
                put_res(b, 1'b1, jsu_pkg::ERR_NONE);
            return;
        end
        if (b[7:5] == 3'b110)
            more = 2'd1;
        else if (b[7:4] == 4'b1110)
            more = 2'd2;
        else if (b[7:3] == 5'b11110)
            more = 2'd3;
        else
        begin
            fail_with(jsu_pkg::ERR_LEAD);
            return;
        end
        // a lead byte that closes the string has nothing left to follow it
        if (fin)
        begin
            fail_with(jsu_pkg::ERR_TRUNC);
            return;
        end
        put_res(b, 1'b1, jsu_pkg::ERR_NONE);
        cont_left = more;
        mode      = MD_CONT;
    endtask

    task automatic esc_in(input logic [7:0] b, input logic sq);
        logic [7:0] v;
        mode = MD_TEXT;
        case (b)
            CH_QUOTE:  v = CH_QUOTE;
            CH_BSLASH: v = CH_BSLASH;
            CH_SLASH:  v = CH_SLASH;
            8'h62:     v = 8'h08;    // b
            8'h66:     v = 8'h0C;    // f
            8'h6E:     v = 8'h0A;    // n
            8'h72:     v = 8'h0D;    // r
            8'h74:     v = 8'h09;    // t
            CH_APOS:
            begin
                if (!sq)
                begin
                    fail_with(jsu_pkg::ERR_ESCAPE);
                    return;
                end
                v = CH_APOS;
            end
            CH_U:
            begin
                mode  = MD_HEX1;
                hex_n = '0;
                accum = '0;
                return;
            end
            default:
            begin
                fail_with(jsu_pkg::ERR_ESCAPE);
                return;
            end
        endcase
        put_res(v, 1'b1, jsu_pkg::ERR_NONE);
    endtask

    // Expand one accepted byte into its results and queue them.
    task automatic unescape_byte(input jsu_pkg::item_t it);
        logic [7:0]  b;
        int          h;
        logic [20:0] pair_cp;
        b      = it.in_byte;
        step_n = 0;
        case (mode)
            MD_TEXT: text_in(b, it.string_end);
            MD_ESC:  esc_in(b, it.single_quoted);
            MD_HEX1, MD_HEX2:
            begin
                h = hex_nibble_value(b);
                if (h < 0)
                    fail_with(jsu_pkg::ERR_HEX);
                else
                begin
                    accum = {accum[11:0], h[3:0]};
                    hex_n = hex_n + 3'd1;
                    if (hex_n == 3'd4)
                    begin
                        hex_n = '0;
                        if (mode == MD_HEX2)
                        begin
                            // the second escape pairs by its low 10 bits only
                            pair_cp = 21'h10000 + {1'b0, hi_bits, accum[9:0]};
                            emit_code(pair_cp);
                            mode = MD_TEXT;
                        end
                        else if (accum >= 16'hD800 && accum <= 16'hDBFF)
                        begin
                            hi_bits = accum[9:0];
                            mode    = MD_SBS;
                        end
                        else
                        begin
                            emit_code({5'b0, accum});
                            mode = MD_TEXT;
                        end
                        accum = '0;
                    end
                end
            end
            MD_SBS:
            begin
                if (b == CH_BSLASH)
                    mode = MD_SU;
                else
                begin
                    emit_lone();
                    mode = MD_TEXT;
                    text_in(b, it.string_end);
                end
            end
            MD_SU:
            begin
                if (b == CH_U)
                begin
                    mode  = MD_HEX2;
                    hex_n = '0;
                    accum = '0;
                end
                else
                begin
                    emit_lone();
                    esc_in(b, it.single_quoted);
                end
            end
            MD_CONT:
            begin
                put_res(b, 1'b1, jsu_pkg::ERR_NONE);
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                    mode = MD_TEXT;
            end
            default: ;
        endcase

        if (it.string_end)
        begin
            case (mode)
                MD_ESC, MD_SU:    fail_with(jsu_pkg::ERR_ESCAPE);
                MD_HEX1, MD_HEX2: fail_with(jsu_pkg::ERR_HEX);
                MD_SBS:           emit_lone();
                MD_CONT:          fail_with(jsu_pkg::ERR_TRUNC);
                default: ;
            endcase
            mode      = MD_TEXT;
            hex_n     = '0;
            accum     = '0;
            hi_bits   = '0;
            cont_left = '0;
            // a closing byte with nothing else to say still gives a marker
            if (step_n == 0)
                put_res(8'h00, 1'b0, jsu_pkg::ERR_NONE);
        end

        if (step_n > 0)
        begin
            step_res[step_n-1].run_last    = 1'b1;
            step_res[step_n-1].string_done = it.string_end;
        end
        for (int i = 0; i < step_n; i++)
            decoded_q.insert(decoded_q.size(), step_res[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_digit(input logic [3:0] nib, input bit up);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return (up ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    // Append one byte to the string under construction.
    task automatic add_byte(input logic [7:0] x);
        str_bytes.insert(str_bytes.size(), x);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // \uXXXX with a random mix of upper and lower case digits.
    task automatic add_uesc(input logic [15:0] cu);
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        for (int k = 3; k >= 0; k--)
            add_byte(hex_digit(cu[k*4 +: 4], 1'($urandom_range(0, 1))));
    endtask

    // Move the string under construction to the send queue; the last byte
    // carries string_end.
    task automatic flush_string(input bit sq, input bit drain);
        raw_byte_t rb;
        foreach (str_bytes[i])
        begin
            rb.it.in_byte       = str_bytes[i];
            rb.it.single_quoted = sq;
            rb.it.string_end    = (i == str_bytes.size() - 1);
            rb.hold_for_drain   = drain && (i == 0);
            raw_q.insert(raw_q.size(), rb);
        end
        str_bytes.delete();
    endtask

    // One random piece of string content, mostly well formed.
    task automatic add_token();
        int          pick;
        int          ncont;
        logic [15:0] cu;
        logic [7:0]  b;
        logic [7:0]  esc_set [9];
        esc_set = '{CH_QUOTE, CH_BSLASH, CH_SLASH, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74,
                    CH_APOS};
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            b = 8'($urandom_range(8'h20, 8'h7E));
            add_byte(b == CH_BSLASH ? 8'h41 : b);
        end
        else if (pick < 42)
        begin
            add_byte(CH_BSLASH);
            add_byte(esc_set[$urandom_range(0, 8)]);
        end
        else if (pick < 54)
            add_uesc(16'($urandom_range(0, 16'hFFFF)));
        else if (pick < 66)
        begin
            // surrogate pair; now and then the partner is a random code unit
            add_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
            if ($urandom_range(0, 5) == 0)
                add_uesc(16'($urandom_range(0, 16'hFFFF)));
            else
                add_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        else if (pick < 72)
            add_uesc(16'($urandom_range(16'hD800, 16'hDBFF)));
        else if (pick < 76)
            add_uesc(16'($urandom_range(16'hDC00, 16'hDFFF)));
        else if (pick < 90)
        begin
            ncont = $urandom_range(1, 3);
            case (ncont)
                1:       add_byte(8'($urandom_range(8'hC0, 8'hDF)));
                2:       add_byte(8'($urandom_range(8'hE0, 8'hEF)));
                default: add_byte(8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            // continuation bytes pass through unchecked, so any value goes
            repeat (ncont)
                add_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (pick < 94)
            add_byte(8'($urandom_range(0, 8'h1F)));
        else if (pick < 97)
            add_byte(8'($urandom_range(0, 255)));
        else
        begin
            // broken escape: a stray escape letter or a short hex run
            add_byte(CH_BSLASH);
            if ($urandom_range(0, 1) == 0)
                add_byte(8'($urandom_range(0, 255)));
            else
            begin
                add_byte(CH_U);
                repeat ($urandom_range(0, 3))
                    add_byte(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                add_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic build_stimulus();
        bit sq;
        bit first;
        int cut;
        // Directed strings: extremes and special cases.
        add_byte(8'h00);                        // control byte
        flush_string(1'b0, 1'b0);
        add_byte(8'hFF);                        // bad lead byte
        flush_string(1'b1, 1'b0);
        add_byte(8'hF4);                        // lead byte as the last byte
        flush_string(1'b0, 1'b0);
        add_byte(8'hE2);                        // ends with a continuation missing
        add_byte(8'h82);
        flush_string(1'b0, 1'b0);
        add_text("\\");                         // ends on a bare backslash
        flush_string(1'b0, 1'b0);
        add_text("\\'");                        // apostrophe escape, single-quoted
        flush_string(1'b1, 1'b0);
        add_text("\\'");                        // apostrophe escape, double-quoted
        flush_string(1'b0, 1'b0);
        add_text("\\uDBFF");                    // ends after a high surrogate
        flush_string(1'b0, 1'b0);
        add_text("\\ud800\\n");                 // lone high surrogate, then an escape
        flush_string(1'b1, 1'b0);

        // Random strings; some are cut short to end inside an escape or a
        // multibyte sequence.
        first = 1'b1;
        while (raw_q.size() < TARGET_BYTES)
        begin
            sq = 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 5))
                add_token();
            if ($urandom_range(0, 7) == 0 && str_bytes.size() > 1)
            begin
                cut = $urandom_range(1, str_bytes.size() - 1);
                repeat (cut)
                    void'(str_bytes.pop_back());
            end
            flush_string(sq, first || ($urandom_range(0, 29) == 0));
            first = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of random length separated by random gaps. An item
    // stays on the bus until its transfer; a string marked for drain waits
    // until every expected result has been popped.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin : drive_proc
        bit        go;
        raw_byte_t nxt;
        go = 1'b0;
        if (!rst_n)
            go = 1'b0;
        else if (push && !took_byte)
            go = 1'b1;                          // hold until the transfer
        else if (gap_left > 0)
            gap_left--;
        else if (raw_q.size() != 0 && !(raw_q[0].hold_for_drain && decoded_q.size() != 0))
        begin
            nxt  = raw_q.pop_front();
            item <= nxt.it;
            go   = 1'b1;
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        push <= go;
    end

    // ------------------------------------------------------------------
    // Receiver: alternate free-running, random and fully stalled stretches.
    // ------------------------------------------------------------------
    int rx_left = 0;
    int rx_kind = 0;

    always @(negedge clk)
    begin : pop_proc
        if (rx_left == 0)
        begin
            rx_kind = $urandom_range(0, 2);
            rx_left = (rx_kind == 2) ? $urandom_range(1, 8) : $urandom_range(5, 40);
        end
        rx_left--;
        case (rx_kind)
            0:       pop <= rst_n;
            1:       pop <= rst_n && ($urandom_range(0, 1) == 1);
            default: pop <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes at the rising edge. Check the popped
    // result against the oldest expectation, then predict for the byte
    // transferred at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : mon_proc
        jsu_pkg::result_t want;
        took_byte = 1'b0;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result %h with nothing expected", result));
                else
                begin
                    want = decoded_q.pop_front();
                    if (result.out_byte !== want.out_byte)
                        report_mismatch($sformatf("result %0d out_byte %h, want %h",
                                                  popped, result.out_byte, want.out_byte));
                    if (result.out_valid !== want.out_valid)
                        report_mismatch($sformatf("result %0d out_valid %b, want %b",
                                                  popped, result.out_valid, want.out_valid));
                    if (result.error_code !== want.error_code)
                        report_mismatch($sformatf("result %0d error_code %0d, want %0d",
                                                  popped, result.error_code, want.error_code));
                    if (result.run_last !== want.run_last)
                        report_mismatch($sformatf("result %0d run_last %b, want %b",
                                                  popped, result.run_last, want.run_last));
                    if (result.string_done !== want.string_done)
                        report_mismatch($sformatf("result %0d string_done %b, want %b",
                                                  popped, result.string_done,
                                                  want.string_done));
                end
                popped++;
            end
            if (push && !full)
            begin
                unescape_byte(item);
                took_byte = 1'b1;
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, wait for all transfers and results,
    // allow a short tail for stray results, then give the verdict.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        push  = 1'b0;
        pop   = 1'b0;
        item  = '0;
        build_stimulus();
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (raw_q.size() != 0 || push)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### json_string_unescape_utf8_top.f
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescape_utf8_top.sv
hdl/jsu_checker.sv
bench/tb.sv
